// File: hw/rtl/lrb_pkg.sv
// Shared types, constants and codes for the link retry backoff supervisor.
package lrb_pkg;

    localparam int LADDER_LEN = 4;
    localparam int LADDER_W   = (LADDER_LEN > 1) ? $clog2(LADDER_LEN) : 1;
    localparam int NUM_STEPS  = 4;
    localparam int STEP_W     = 12;
    localparam int TRY_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TRY_W-1:0]  FAST_RETRY_RST = 4'd5;
    localparam logic [STEP_W-1:0] STEP0_RST      = 12'd30;
    localparam logic [STEP_W-1:0] STEP1_RST      = 12'd60;
    localparam logic [STEP_W-1:0] STEP2_RST      = 12'd120;
    localparam logic [STEP_W-1:0] STEP3_RST      = 12'd300;

    typedef enum logic [2:0] {
        REQ_CONNECT    = 3'd0,
        REQ_DISCONNECT = 3'd1,
        REQ_FORGET     = 3'd2,
        REQ_RADIO_UP   = 3'd3,
        REQ_LINK_LOST  = 3'd4,
        REQ_ADDR       = 3'd5,
        REQ_TICK       = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_CONNECTING = 3'd1,
        MODE_CONNECTED  = 3'd2,
        MODE_RETRYING   = 3'd3,
        MODE_FAILED     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_WRONG_PASS = 3'd1,
        ERR_NOT_FOUND  = 3'd2,
        ERR_LOST       = 3'd3,
        ERR_NO_SAVED   = 3'd4,
        ERR_RADIO      = 3'd5,
        ERR_START      = 3'd6
    } err_t;

    localparam logic [1:0] LOSS_AUTH      = 2'd1;
    localparam logic [1:0] LOSS_NOT_FOUND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_RETRY = 3'd0,
        CFG_STEP0      = 3'd1,
        CFG_STEP1      = 3'd2,
        CFG_STEP2      = 3'd3,
        CFG_STEP3      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       credentials_given;
        logic       radio_ok;
        logic [1:0] loss_reason;
    } item_t;

    typedef struct packed {
        logic [2:0]        link_state;
        logic [2:0]        error_code;
        logic              request_refused;
        logic              connect_cmd;
        logic              stop_cmd;
        logic [STEP_W-1:0] wait_left;
    } result_t;

    typedef struct packed {
        logic [TRY_W-1:0]                   fast_retry_limit;
        logic [NUM_STEPS-1:0][STEP_W-1:0]   backoff_step;
    } cfg_t;

endpackage

// File: hw/rtl/lrb_if.sv
// Valid/ready channel interfaces for input items and result items.
interface lrb_item_if
    import lrb_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lrb_result_if
    import lrb_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/link_retry_backoff_supervisor.sv
// Link retry backoff supervisor: item register, core update, result register.
// An accepted event beat waits in the item register; its result is then held in the result register.
// Throughput: one event beat per cycle while results are taken; the state update is one short pass
// through the core between the item register and the result register.
// A held result stalls intake only once the item register is also full.
// Reset (rst_n, async low) sets mode off, clears errors, timer and flags,
// and loads the default retry limit and backoff ladder.
module link_retry_backoff_supervisor
    import lrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data,
    lrb_item_if.sink             item,
    lrb_result_if.source         result
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;

    lrb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrb_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    // move the held beat into the result slot when that slot frees up
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
            item_reg <= item.data;
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

// File: hw/rtl/lrb_cfg_regs.sv
// Configuration register file: retry limit and backoff ladder steps.
module lrb_cfg_regs
    import lrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_retry_limit <= FAST_RETRY_RST;
            cfg_reg.backoff_step[0]  <= STEP0_RST;
            cfg_reg.backoff_step[1]  <= STEP1_RST;
            cfg_reg.backoff_step[2]  <= STEP2_RST;
            cfg_reg.backoff_step[3]  <= STEP3_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FAST_RETRY: cfg_reg.fast_retry_limit <= cfg_data[TRY_W-1:0];
                CFG_STEP0:      cfg_reg.backoff_step[0]  <= cfg_data;
                CFG_STEP1:      cfg_reg.backoff_step[1]  <= cfg_data;
                CFG_STEP2:      cfg_reg.backoff_step[2]  <= cfg_data;
                CFG_STEP3:      cfg_reg.backoff_step[3]  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/lrb_core.sv
// Supervisor state and the single-pass update for one event beat.
module lrb_core
    import lrb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    mode_t              mode_reg, mode_next;
    err_t               err_reg, err_next;
    logic               want_reg, want_next;
    logic               ready_reg, ready_next;
    logic               saved_reg, saved_next;
    logic [TRY_W-1:0]   tries_reg, tries_next;
    logic [LADDER_W-1:0] ladder_reg, ladder_next;
    logic [STEP_W-1:0]  wait_reg, wait_next;

    always_comb
    begin
        logic        do_enter;
        mode_t       enter_mode;
        err_t        enter_err;
        logic [1:0]  slot;
        logic [STEP_W-1:0] secs;

        mode_next   = mode_reg;
        err_next    = err_reg;
        want_next   = want_reg;
        ready_next  = ready_reg;
        saved_next  = saved_reg;
        tries_next  = tries_reg;
        ladder_next = ladder_reg;
        wait_next   = wait_reg;
        do_enter    = 1'b0;
        enter_mode  = mode_reg;
        enter_err   = ERR_NONE;
        slot        = 2'd0;
        secs        = '0;

        result = '0;

        case (item.req_type)
            REQ_CONNECT:
            begin
                saved_next = saved_reg | item.credentials_given;
                if (!saved_next)
                    result.request_refused = 1'b1;
                else if (!item.radio_ok)
                begin
                    do_enter   = 1'b1;
                    enter_mode = MODE_FAILED;
                    enter_err  = ERR_START;
                end
                else
                begin
                    ready_next  = 1'b1;
                    tries_next  = '0;
                    ladder_next = '0;
                    want_next   = 1'b1;
                    do_enter    = 1'b1;
                    enter_mode  = MODE_CONNECTING;
                    result.connect_cmd = 1'b1;
                end
            end
            REQ_DISCONNECT:
            begin
                want_next = 1'b0;
                if (ready_reg)
                begin
                    tries_next      = cfg.fast_retry_limit;
                    result.stop_cmd = 1'b1;
                end
                do_enter   = 1'b1;
                enter_mode = MODE_OFF;
            end
            REQ_FORGET:
            begin
                want_next  = 1'b0;
                saved_next = 1'b0;
            end
            REQ_RADIO_UP:
                result.connect_cmd = want_reg;
            REQ_LINK_LOST:
            begin
                do_enter = 1'b1;
                if (item.loss_reason == LOSS_AUTH)
                begin
                    enter_mode = MODE_FAILED;
                    enter_err  = ERR_WRONG_PASS;
                end
                else if (!want_reg)
                    enter_mode = MODE_OFF;
                else if (tries_reg < cfg.fast_retry_limit)
                begin
                    tries_next = tries_reg + 1'b1;
                    enter_mode = MODE_CONNECTING;
                    result.connect_cmd = 1'b1;
                end
                else
                begin
                    enter_mode = MODE_RETRYING;
                    enter_err  = (item.loss_reason == LOSS_NOT_FOUND) ? ERR_NOT_FOUND
                                                                      : ERR_LOST;
                end
            end
            REQ_ADDR:
            begin
                tries_next  = '0;
                ladder_next = '0;
                do_enter    = 1'b1;
                enter_mode  = MODE_CONNECTED;
            end
            REQ_TICK:
            begin
                if (mode_reg == MODE_RETRYING && wait_reg != '0)
                begin
                    wait_next = wait_reg - 1'b1;
                    // expiry only reconnects when a link is still wanted
                    if (wait_next == '0 && want_reg && ready_reg)
                    begin
                        do_enter = 1'b1;
                        if (!saved_reg)
                        begin
                            enter_mode = MODE_FAILED;
                            enter_err  = ERR_NO_SAVED;
                        end
                        else
                        begin
                            tries_next = '0;
                            if (item.radio_ok)
                            begin
                                enter_mode = MODE_CONNECTING;
                                result.connect_cmd = 1'b1;
                            end
                            else
                            begin
                                enter_mode = MODE_FAILED;
                                enter_err  = ERR_RADIO;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        if (do_enter)
        begin
            mode_next = enter_mode;
            if (enter_mode == MODE_CONNECTING || enter_mode == MODE_CONNECTED ||
                enter_mode == MODE_OFF)
                err_next = ERR_NONE;
            else
                err_next = enter_err;
            if (enter_mode != MODE_RETRYING)
                wait_next = '0;
            else
            begin
                // arm from the ladder; entries past the last step reuse it
                slot = (int'(ladder_next) >= NUM_STEPS - 1) ? 2'(NUM_STEPS - 1)
                                                            : 2'(ladder_next);
                secs = cfg.backoff_step[slot];
                wait_next = (secs == '0) ? STEP_W'(1) : secs;
                if (int'(ladder_next) + 1 < LADDER_LEN)
                    ladder_next = ladder_next + 1'b1;
            end
        end

        result.link_state = mode_next;
        result.error_code = err_next;
        result.wait_left  = wait_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            err_reg    <= ERR_NONE;
            want_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            saved_reg  <= 1'b0;
            tries_reg  <= '0;
            ladder_reg <= '0;
            wait_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            err_reg    <= err_next;
            want_reg   <= want_next;
            ready_reg  <= ready_next;
            saved_reg  <= saved_next;
            tries_reg  <= tries_next;
            ladder_reg <= ladder_next;
            wait_reg   <= wait_next;
        end
    end

    a_wait_only_retrying: assert property (@(posedge clk) disable iff (!rst_n)
        (wait_reg != '0) |-> (mode_reg == MODE_RETRYING))
        else $error("backoff wait running outside retrying");

    a_ladder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ladder_reg) <= LADDER_LEN - 1)
        else $error("ladder index past last entry");

    a_arm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg != MODE_RETRYING && mode_next == MODE_RETRYING)
        |=> (wait_reg != '0))
        else $error("retrying entered with no wait armed");

endmodule
